/* rtl/core/sqd_pkg.sv */
// shared types and constants for the shortest queue dispatcher
`timescale 1ns / 1ps

package sqd_pkg;

  localparam int REC_W     = 40;
  localparam int ID_W      = 16;
  localparam int FUEL_W    = 8;
  localparam int WAIT_W    = 16;
  localparam int CFG_W     = 3;
  localparam int MIN_QUEUES = 3;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    FN_ARRIVE = 1'b0,
    FN_POP    = 1'b1
  } func_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  typedef struct packed {
    status_t status;
    logic    pop_hit;
  } disp_info_t;

  typedef struct packed {
    logic en;
    logic we;
  } mem_ctl_t;

endpackage

/* rtl/core/sqd_record_mem.sv */
// single-port record memory with registered read data
`timescale 1ns / 1ps

module sqd_record_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                     clk,
  input  sqd_pkg::mem_ctl_t        ctl,
  input  logic [AW-1:0]            addr,
  input  logic [sqd_pkg::REC_W-1:0] wdata,
  output logic [sqd_pkg::REC_W-1:0] rdata
);
  import sqd_pkg::*;

  logic [REC_W-1:0] mem [DEPTH];
  logic [REC_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/sqd_queue_ctrl.sv */
// queue pointers and counts, shortest queue choice and memory addressing
`timescale 1ns / 1ps

module sqd_queue_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_QUEUES  = 4,
  parameter int QW = 2,
  parameter int CW = 5,
  parameter int AW = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic                      func,
  input  logic [QW-1:0]             sel,
  input  logic [sqd_pkg::CFG_W-1:0] active,
  output sqd_pkg::disp_info_t       info,
  output logic [QW-1:0]             q_idx,
  output logic [CW-1:0]             q_count,
  output sqd_pkg::mem_ctl_t         mem_ctl,
  output logic [AW-1:0]             mem_addr
);
  import sqd_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [PW-1:0] head_r [MAX_QUEUES];
  logic [PW-1:0] head_nxt [MAX_QUEUES];
  logic [PW-1:0] tail_r [MAX_QUEUES];
  logic [PW-1:0] tail_nxt [MAX_QUEUES];
  logic [CW-1:0] cnt_r [MAX_QUEUES];
  logic [CW-1:0] cnt_nxt [MAX_QUEUES];

  logic [31:0]   n_use;
  logic [QW-1:0] q_min;
  logic [CW-1:0] c_min;
  logic          sel_used;
  logic          sel_exists;
  logic [CW-1:0] c_sel;
  logic [PW-1:0] ptr;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(QUEUE_DEPTH - 1)) r = '0;
    else                           r = p + PW'(1);
    return r;
  endfunction

  always_comb begin
    n_use = 32'(active);
    if (n_use < MIN_QUEUES) n_use = MIN_QUEUES;
    if (n_use > MAX_QUEUES) n_use = MAX_QUEUES;

    q_min = '0;
    c_min = cnt_r[0];
    for (int i = 1; i < MAX_QUEUES; i++) begin
      if ((i < n_use) && (cnt_r[i] < c_min)) begin
        q_min = QW'(i);
        c_min = cnt_r[i];
      end
    end

    sel_exists = (32'(sel) < MAX_QUEUES);
    sel_used   = (32'(sel) < n_use);
    c_sel      = sel_exists ? cnt_r[sel] : '0;

    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    info.status  = ST_DONE;
    info.pop_hit = 1'b0;
    mem_ctl.en   = 1'b0;
    mem_ctl.we   = 1'b0;
    ptr          = '0;

    if (func == FN_ARRIVE) begin
      q_idx = q_min;
      if (32'(c_min) >= QUEUE_DEPTH) begin
        info.status = ST_FULL;
        q_count     = c_min;
      end else begin
        ptr         = tail_r[q_min];
        mem_ctl.en  = go;
        mem_ctl.we  = 1'b1;
        q_count     = c_min + CW'(1);
        if (go) begin
          tail_nxt[q_min] = bump(tail_r[q_min]);
          cnt_nxt[q_min]  = c_min + CW'(1);
        end
      end
    end else begin
      q_idx = sel;
      if (!sel_used || (c_sel == '0)) begin
        info.status = ST_EMPTY;
        q_count     = c_sel;
      end else begin
        info.pop_hit = 1'b1;
        ptr          = head_r[sel];
        mem_ctl.en   = go;
        q_count      = c_sel - CW'(1);
        if (go) begin
          head_nxt[sel] = bump(head_r[sel]);
          cnt_nxt[sel]  = c_sel - CW'(1);
        end
      end
    end

    mem_addr = AW'(q_idx) * AW'(QUEUE_DEPTH) + AW'(ptr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_QUEUES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/shortest_queue_dispatcher.sv */
// top level of the shortest queue dispatcher
`timescale 1ns / 1ps

// Join-shortest-queue dispatcher over MAX_QUEUES record queues of QUEUE_DEPTH
// entries each, with all records held in one single-port memory. Each input
// transaction produces exactly one result. On acceptance the controller
// updates pointers and counts and accesses the record memory; in the read
// state the registered read data enters the output register once that is
// free. in_stall is high in the read state, so the next transaction is
// accepted only after the last loaded its result. A finished result may
// wait in the output register while the next transaction is accepted.
// active_queues (cfg_data, reset 4) is written through the cfg port, which
// is always ready; values below 3 act as 3, above MAX_QUEUES as MAX_QUEUES.
module shortest_queue_dispatcher #(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_QUEUES  = 4
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [sqd_pkg::CFG_W-1:0]                cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     in_func,
  input  logic [$clog2(MAX_QUEUES)-1:0]            in_queue_sel,
  input  logic [sqd_pkg::ID_W-1:0]                 in_plane_id,
  input  logic [sqd_pkg::FUEL_W-1:0]               in_fuel_units,
  input  logic [sqd_pkg::WAIT_W-1:0]               in_wait_time,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [1:0]                               out_status,
  output logic [$clog2(MAX_QUEUES)-1:0]            out_queue_index,
  output logic [sqd_pkg::ID_W-1:0]                 out_id,
  output logic [sqd_pkg::FUEL_W-1:0]               out_fuel,
  output logic [sqd_pkg::WAIT_W-1:0]               out_wait,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]         out_queue_count
);
  import sqd_pkg::*;

  localparam int QW    = $clog2(MAX_QUEUES);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int DEPTH = MAX_QUEUES * QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] active_r;
  logic             accept;
  logic             load_out;

  disp_info_t       info;
  logic [QW-1:0]    q_idx;
  logic [CW-1:0]    q_count;
  mem_ctl_t         mem_ctl;
  logic [AW-1:0]    mem_addr;
  logic [REC_W-1:0] rdata;

  disp_info_t       info_r;
  logic [QW-1:0]    q_r;
  logic [CW-1:0]    count_r;

  logic             out_valid_r;
  logic [1:0]       status_r;
  logic [QW-1:0]    qi_r;
  logic [ID_W-1:0]  id_r;
  logic [FUEL_W-1:0] fuel_r;
  logic [WAIT_W-1:0] wait_r;
  logic [CW-1:0]    qc_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;

  sqd_queue_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_QUEUES  (MAX_QUEUES),
    .QW          (QW),
    .CW          (CW),
    .AW          (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (accept),
    .func     (in_func),
    .sel      (in_queue_sel),
    .active   (active_r),
    .info     (info),
    .q_idx    (q_idx),
    .q_count  (q_count),
    .mem_ctl  (mem_ctl),
    .mem_addr (mem_addr)
  );

  sqd_record_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata ({in_wait_time, in_fuel_units, in_plane_id}),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_READ;
      end
      S_READ: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= CFG_W'(4);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) active_r <= cfg_data;
      if (load_out)                    out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      info_r  <= info;
      q_r     <= q_idx;
      count_r <= q_count;
    end
    if (load_out) begin
      status_r <= info_r.status;
      qi_r     <= q_r;
      qc_r     <= count_r;
      id_r     <= info_r.pop_hit ? rdata[ID_W-1:0] : '0;
      fuel_r   <= info_r.pop_hit ? rdata[ID_W+FUEL_W-1:ID_W] : '0;
      wait_r   <= info_r.pop_hit ? rdata[REC_W-1:ID_W+FUEL_W] : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_queue_index = qi_r;
  assign out_id          = id_r;
  assign out_fuel        = fuel_r;
  assign out_wait        = wait_r;
  assign out_queue_count = qc_r;

endmodule
